>>> src/idu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idu_pkg: shared types and constants of the impact detector
// Configuration, item, result and state records, register indexes and the
// fixed-point constants of the averaging and flash logic.
// ----------------------------------------------------------------------------
package idu_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_IMPACT_THRESHOLD  = 2'd0;
   localparam logic [1:0] CSR_MIN_INTERVAL_MS   = 2'd1;
   localparam logic [1:0] CSR_FLASH_DURATION_MS = 2'd2;

   localparam logic [15:0] THRESHOLD_RESET = 16'd3840;
   localparam logic [15:0] INTERVAL_RESET  = 16'd40;
   localparam logic [15:0] DURATION_RESET  = 16'd1400;

   localparam logic [15:0] AVG_RESET = 16'd2511;
   localparam logic [7:0]  AVG_KEEP  = 8'd179;
   localparam logic [7:0]  AVG_NEW   = 8'd77;
   localparam logic [24:0] AVG_ROUND = 25'd128;

   localparam logic [7:0] LED_FLASH = 8'd255;
   localparam logic [7:0] LED_WARN  = 8'd60;
   localparam logic [7:0] LED_OFF   = 8'd0;

   // floor(x / 5) = (x * DIV5_RECIP) >> DIV5_SHIFT for x below 4096
   localparam logic [11:0] DIV5_RECIP = 12'd3277;
   localparam int          DIV5_SHIFT = 14;

   typedef struct packed {
      logic [15:0] impact_threshold;
      logic [15:0] min_interval_ms;
      logic [15:0] flash_duration_ms;
   } idu_cfg_type;

   typedef struct packed {
      logic [15:0] sample_mag;
      logic [31:0] now_ms;
      logic        select_pressed;
      logic        select_long;
   } idu_item_type;

   typedef struct packed {
      logic        stay;
      logic        processed;
      logic [7:0]  led_level;
      logic [15:0] smooth_mag;
      logic [15:0] peak_mag;
      logic        event_active;
      logic        flash_on;
      logic        new_impact;
      logic [1:0]  log_slot;
      logic [15:0] impact_count;
   } idu_result_type;

   typedef struct packed {
      logic [15:0] avg_mag;
      logic [15:0] peak_hold;
      logic [31:0] last_update_ms;
      logic        event_on;
      logic [31:0] event_start_ms;
      logic [15:0] count_impacts;
      logic [7:0]  led_hold;
   } idu_state_type;

endpackage

>>> src/idu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idu_if: valid/ready channels of the impact detector
// Sample request channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface idu_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] sample_mag;
   logic [31:0] now_ms;
   logic        select_pressed;
   logic        select_long;

   modport source (output valid, output sample_mag, output now_ms,
                   output select_pressed, output select_long, input ready);
   modport sink   (input valid, input sample_mag, input now_ms,
                   input select_pressed, input select_long, output ready);
endinterface

interface idu_rsp_if;
   logic        valid;
   logic        ready;
   logic        stay;
   logic        processed;
   logic [7:0]  led_level;
   logic [15:0] smooth_mag;
   logic [15:0] peak_mag;
   logic        event_active;
   logic        flash_on;
   logic        new_impact;
   logic [1:0]  log_slot;
   logic [15:0] impact_count;

   modport source (output valid, output stay, output processed, output led_level,
                   output smooth_mag, output peak_mag, output event_active,
                   output flash_on, output new_impact, output log_slot,
                   output impact_count, input ready);
   modport sink   (input valid, input stay, input processed, input led_level,
                   input smooth_mag, input peak_mag, input event_active,
                   input flash_on, input new_impact, input log_slot,
                   input impact_count, output ready);
endinterface

>>> src/idu_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idu_step: one sample update of the impact detector
// Interval check, averaging, peak hold, event start/end, flash phase and LED.
// ----------------------------------------------------------------------------
module idu_step
   import idu_pkg::*;
#(
   parameter int LOG_DEPTH = 4,
   parameter int SLOT_W    = 2
) (
   input  idu_cfg_type    cfg,
   input  idu_state_type  state,
   input  logic [SLOT_W-1:0] slot_cur,
   input  idu_item_type   item,
   output idu_state_type  state_next,
   output logic [SLOT_W-1:0] slot_next,
   output idu_result_type result
);

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(LOG_DEPTH - 1);

   logic [31:0] since_last;
   logic        skip;
   logic [23:0] avg_keep_prod;
   logic [23:0] avg_new_prod;
   logic [24:0] avg_sum;
   logic [15:0] avg_upd;
   logic [15:0] peak_upd;
   logic        start;
   logic        ev_run;
   logic [31:0] start_ms;
   logic [31:0] elapsed;
   logic        in_flash;
   logic [23:0] phase_prod;
   logic        flash;
   logic [23:0] warn_prod;
   logic [15:0] warn_level;
   logic [7:0]  led;
   logic [SLOT_W+1:0] slot_wide;

   assign since_last    = item.now_ms - state.last_update_ms;
   assign skip          = since_last < {16'd0, cfg.min_interval_ms};
   assign avg_keep_prod = state.avg_mag * AVG_KEEP;
   assign avg_new_prod  = item.sample_mag * AVG_NEW;
   assign avg_sum       = {1'b0, avg_keep_prod} + {1'b0, avg_new_prod} + AVG_ROUND;
   assign avg_upd       = avg_sum[23:8];
   assign peak_upd      = (item.sample_mag > state.peak_hold) ? item.sample_mag
                                                              : state.peak_hold;
   assign start         = (item.sample_mag > cfg.impact_threshold) && !state.event_on;
   assign ev_run        = state.event_on || start;
   assign start_ms      = start ? item.now_ms : state.event_start_ms;
   assign elapsed       = item.now_ms - start_ms;
   assign in_flash      = elapsed < {16'd0, cfg.flash_duration_ms};
   // elapsed fits 16 bits while flashing; phase = (elapsed >> 4) / 5
   assign phase_prod    = elapsed[15:4] * DIV5_RECIP;
   assign flash         = ev_run && in_flash && !phase_prod[DIV5_SHIFT];
   assign warn_prod     = cfg.impact_threshold * AVG_KEEP;
   assign warn_level    = warn_prod[23:8];
   assign slot_wide     = {2'b00, slot_cur};

   always_comb begin
      if (ev_run && in_flash) begin
         led = flash ? LED_FLASH : LED_OFF;
      end else begin
         led = (avg_upd > warn_level) ? LED_WARN : LED_OFF;
      end
   end

   always_comb begin
      state_next          = state;
      slot_next           = slot_cur;
      result.stay         = 1'b1;
      result.processed    = 1'b0;
      result.led_level    = state.led_hold;
      result.smooth_mag   = state.avg_mag;
      result.peak_mag     = state.peak_hold;
      result.event_active = state.event_on;
      result.flash_on     = 1'b0;
      result.new_impact   = 1'b0;
      result.log_slot     = 2'd0;
      result.impact_count = state.count_impacts;
      if (item.select_long) begin
         state_next.led_hold = LED_OFF;
         result.stay         = 1'b0;
         result.led_level    = LED_OFF;
      end else if (!skip) begin
         state_next.last_update_ms = item.now_ms;
         state_next.avg_mag        = avg_upd;
         state_next.peak_hold      = item.select_pressed ? 16'd0 : peak_upd;
         state_next.event_on       = ev_run && in_flash;
         state_next.event_start_ms = start_ms;
         state_next.led_hold       = led;
         if (start) begin
            state_next.count_impacts = state.count_impacts + 16'd1;
            // keep the slot equal to the count modulo the ring depth
            if (state.count_impacts == 16'hFFFF || slot_cur == SLOT_LAST) begin
               slot_next = '0;
            end else begin
               slot_next = slot_cur + 1'b1;
            end
         end
         result.processed    = 1'b1;
         result.led_level    = led;
         result.smooth_mag   = avg_upd;
         result.peak_mag     = peak_upd;
         result.event_active = ev_run && in_flash;
         result.flash_on     = flash;
         result.new_impact   = start;
         result.log_slot     = start ? slot_wide[1:0] : 2'd0;
         result.impact_count = state_next.count_impacts;
      end
   end

endmodule

>>> src/impact_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// impact_detector_unit: acceleration impact detector
// Averages magnitude samples, holds the peak, detects impact events, and
// drives a flashing/warning LED level; one result word per sample word.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  req_chan  in    valid/ready    sample_mag, now_ms, select_pressed, select_long
//  rsp_chan  out   valid/ready    stay .. impact_count (one word per request)
//  csr_*     in    write enable   csr_index, csr_data (16 bits)
//
//  One word per cycle unless the result stalls; a word passes the input
//  register, then the output register. The state update is done in the
//  cycle a word leaves the input register, so the next word sees it at
//  once. Reset restores the register defaults and the detector state. A
//  stalled result holds the output register and, behind it, one input word.
// ----------------------------------------------------------------------------
module impact_detector_unit
   import idu_pkg::*;
#(
   parameter int LOG_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   idu_req_if.sink     req_chan,
   idu_rsp_if.source   rsp_chan,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int SLOT_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

   idu_cfg_type       cfg_ff;
   idu_state_type     state_ff;
   idu_state_type     state_in;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in;
   idu_item_type      item_ff;
   logic              item_valid_ff;
   idu_result_type    result_in;
   idu_result_type    result_ff;
   logic              result_valid_ff;
   logic              advance;

   // move the held word into the result register when it is free
   assign advance        = item_valid_ff && (!result_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.impact_threshold  <= THRESHOLD_RESET;
         cfg_ff.min_interval_ms   <= INTERVAL_RESET;
         cfg_ff.flash_duration_ms <= DURATION_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_IMPACT_THRESHOLD:  cfg_ff.impact_threshold  <= csr_data;
            CSR_MIN_INTERVAL_MS:   cfg_ff.min_interval_ms   <= csr_data;
            CSR_FLASH_DURATION_MS: cfg_ff.flash_duration_ms <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff.sample_mag     <= req_chan.sample_mag;
         item_ff.now_ms         <= req_chan.now_ms;
         item_ff.select_pressed <= req_chan.select_pressed;
         item_ff.select_long    <= req_chan.select_long;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         item_valid_ff <= req_chan.valid;
      end
   end

   idu_step #(
      .LOG_DEPTH (LOG_DEPTH),
      .SLOT_W    (SLOT_W)
   ) u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .slot_cur   (slot_ff),
      .item       (item_ff),
      .state_next (state_in),
      .slot_next  (slot_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.avg_mag        <= AVG_RESET;
         state_ff.peak_hold      <= '0;
         state_ff.last_update_ms <= '0;
         state_ff.event_on       <= 1'b0;
         state_ff.event_start_ms <= '0;
         state_ff.count_impacts  <= '0;
         state_ff.led_hold       <= '0;
         slot_ff                 <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_valid_ff <= 1'b0;
      end else if (advance) begin
         result_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         result_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid        = result_valid_ff;
   assign rsp_chan.stay         = result_ff.stay;
   assign rsp_chan.processed    = result_ff.processed;
   assign rsp_chan.led_level    = result_ff.led_level;
   assign rsp_chan.smooth_mag   = result_ff.smooth_mag;
   assign rsp_chan.peak_mag     = result_ff.peak_mag;
   assign rsp_chan.event_active = result_ff.event_active;
   assign rsp_chan.flash_on     = result_ff.flash_on;
   assign rsp_chan.new_impact   = result_ff.new_impact;
   assign rsp_chan.log_slot     = result_ff.log_slot;
   assign rsp_chan.impact_count = result_ff.impact_count;

endmodule
